FILE: design/stt_pkg.sv
// Shared types, constants and character-class helpers for the source text tokenizer.
// Used by source_text_tokenizer and by its port checker.
package stt_pkg;

  // Field widths.
  localparam int KIND_W  = 5;
  localparam int POS_W   = 16;
  localparam int SYM_W   = 8;
  localparam int SLEN_W  = 12;
  localparam int DEPTH_W = 8;

  // Limits and reset values.
  localparam logic [POS_W-1:0]   POS_MAX           = {POS_W{1'b1}};
  localparam logic [DEPTH_W-1:0] MAX_COMMENT_DEPTH = 8'd255;
  localparam logic [SLEN_W-1:0]  MAX_LEN_RESET     = 12'd1024;

  // Output queue geometry.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Token kinds.
  localparam logic [KIND_W-1:0] KIND_INT        = 5'd0;
  localparam logic [KIND_W-1:0] KIND_STRING     = 5'd1;
  localparam logic [KIND_W-1:0] KIND_TYPE_ID    = 5'd2;
  localparam logic [KIND_W-1:0] KIND_OBJECT_ID  = 5'd3;
  localparam logic [KIND_W-1:0] KIND_ASSIGN     = 5'd4;
  localparam logic [KIND_W-1:0] KIND_LE         = 5'd5;
  localparam logic [KIND_W-1:0] KIND_PLUS       = 5'd6;
  localparam logic [KIND_W-1:0] KIND_MINUS      = 5'd7;
  localparam logic [KIND_W-1:0] KIND_STAR       = 5'd8;
  localparam logic [KIND_W-1:0] KIND_SLASH      = 5'd9;
  localparam logic [KIND_W-1:0] KIND_EQ         = 5'd10;
  localparam logic [KIND_W-1:0] KIND_LT         = 5'd11;
  localparam logic [KIND_W-1:0] KIND_TILDE      = 5'd12;
  localparam logic [KIND_W-1:0] KIND_AT         = 5'd13;
  localparam logic [KIND_W-1:0] KIND_LPAREN     = 5'd14;
  localparam logic [KIND_W-1:0] KIND_RPAREN     = 5'd15;
  localparam logic [KIND_W-1:0] KIND_LBRACE     = 5'd16;
  localparam logic [KIND_W-1:0] KIND_RBRACE     = 5'd17;
  localparam logic [KIND_W-1:0] KIND_SEMI       = 5'd18;
  localparam logic [KIND_W-1:0] KIND_COLON      = 5'd19;
  localparam logic [KIND_W-1:0] KIND_COMMA      = 5'd20;
  localparam logic [KIND_W-1:0] KIND_DOT        = 5'd21;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN    = 5'd22;
  localparam logic [KIND_W-1:0] KIND_EOF        = 5'd23;
  localparam logic [KIND_W-1:0] KIND_ERR_STR    = 5'd24;
  localparam logic [KIND_W-1:0] KIND_ERR_LONG   = 5'd25;
  localparam logic [KIND_W-1:0] KIND_ERR_CMT    = 5'd26;

  // Characters the scanner looks at.
  localparam logic [SYM_W-1:0] CH_BS     = 8'd8;
  localparam logic [SYM_W-1:0] CH_TAB    = 8'd9;
  localparam logic [SYM_W-1:0] CH_LF     = 8'd10;
  localparam logic [SYM_W-1:0] CH_CR     = 8'd13;
  localparam logic [SYM_W-1:0] CH_FF     = 8'd12;
  localparam logic [SYM_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [SYM_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [SYM_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [SYM_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [SYM_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [SYM_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [SYM_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [SYM_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [SYM_W-1:0] CH_0      = 8'h30;
  localparam logic [SYM_W-1:0] CH_9      = 8'h39;
  localparam logic [SYM_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [SYM_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [SYM_W-1:0] CH_LT     = 8'h3C;
  localparam logic [SYM_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [SYM_W-1:0] CH_AT     = 8'h40;
  localparam logic [SYM_W-1:0] CH_UA     = 8'h41;
  localparam logic [SYM_W-1:0] CH_UZ     = 8'h5A;
  localparam logic [SYM_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [SYM_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [SYM_W-1:0] CH_LA     = 8'h61;
  localparam logic [SYM_W-1:0] CH_LB     = 8'h62;
  localparam logic [SYM_W-1:0] CH_LF_F   = 8'h66;
  localparam logic [SYM_W-1:0] CH_LN     = 8'h6E;
  localparam logic [SYM_W-1:0] CH_LT_T   = 8'h74;
  localparam logic [SYM_W-1:0] CH_LZ     = 8'h7A;
  localparam logic [SYM_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [SYM_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [SYM_W-1:0] CH_TILDE  = 8'h7E;

  // One result word as it sits in the output queue.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  line;
    logic [POS_W-1:0]  column;
    logic [SYM_W-1:0]  sym;
    logic              has;
    logic              tend;
    logic              last;
  } res_t;

  function automatic logic is_space(input logic [SYM_W-1:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [SYM_W-1:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  function automatic logic is_upper(input logic [SYM_W-1:0] b);
    return (b >= CH_UA) && (b <= CH_UZ);
  endfunction

  function automatic logic is_lower(input logic [SYM_W-1:0] b);
    return (b >= CH_LA) && (b <= CH_LZ);
  endfunction

  function automatic logic is_word(input logic [SYM_W-1:0] b);
    return is_digit(b) || is_upper(b) || is_lower(b) || (b == CH_UNDER);
  endfunction

  // Kind of a single-character operator; anything else is unknown.
  function automatic logic [KIND_W-1:0] op_kind(input logic [SYM_W-1:0] b);
    logic [KIND_W-1:0] k;
    case (b)
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_STAR;
      CH_SLASH:  k = KIND_SLASH;
      CH_EQ:     k = KIND_EQ;
      CH_LT:     k = KIND_LT;
      CH_TILDE:  k = KIND_TILDE;
      CH_AT:     k = KIND_AT;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_SEMI:   k = KIND_SEMI;
      CH_COLON:  k = KIND_COLON;
      CH_COMMA:  k = KIND_COMMA;
      CH_DOT:    k = KIND_DOT;
      default:   k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  // Build a result word; the symbol reads as zero when it is not valid.
  function automatic res_t mk_res(input logic [KIND_W-1:0] kind,
                                  input logic [POS_W-1:0]  line,
                                  input logic [POS_W-1:0]  column,
                                  input logic [SYM_W-1:0]  sym,
                                  input logic              has,
                                  input logic              tend);
    res_t r;
    r.kind   = kind;
    r.line   = line;
    r.column = column;
    r.sym    = has ? sym : '0;
    r.has    = has;
    r.tend   = tend;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

FILE: design/source_text_tokenizer.sv
// Streaming tokenizer: one source byte (or end mark) per input word, symbol words out.
// Depends on stt_pkg for widths, token kinds, character constants and the result type.
// Result words are written into the result queue when their input word is taken, and are
// driven from its head. Throughput: one input word per cycle while the input is not stalled
// and each yields at most one result word; results leave one at a time through the single
// output port of the four-entry result queue. Input stalls while it holds three or more words.
// Reset: asynchronous, active low; scanner idle at line 1, column 1, queue empty, and the
// string length limit back to 1024.
module source_text_tokenizer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write channel.
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [stt_pkg::SLEN_W-1:0] cfg_data_i,
  // Input channel.
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [stt_pkg::SYM_W-1:0]  source_byte_i,
  input  logic                       end_of_source_i,
  // Output channel.
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [stt_pkg::KIND_W-1:0] token_kind_o,
  output logic [stt_pkg::POS_W-1:0]  start_line_o,
  output logic [stt_pkg::POS_W-1:0]  start_column_o,
  output logic [stt_pkg::SYM_W-1:0]  text_symbol_o,
  output logic                       has_symbol_o,
  output logic                       token_end_o,
  output logic                       run_last_o
);
  import stt_pkg::*;

  // Scanner modes.
  localparam logic [3:0] M_IDLE   = 4'd0;
  localparam logic [3:0] M_INT    = 4'd1;
  localparam logic [3:0] M_IDENT  = 4'd2;
  localparam logic [3:0] M_PEND   = 4'd3;
  localparam logic [3:0] M_LINE   = 4'd4;
  localparam logic [3:0] M_BLOCK  = 4'd5;
  localparam logic [3:0] M_BPAREN = 4'd6;
  localparam logic [3:0] M_BSTAR  = 4'd7;
  localparam logic [3:0] M_STRING = 4'd8;
  localparam logic [3:0] M_ESC    = 4'd9;
  localparam logic [3:0] M_ERROR  = 4'd10;

  logic [3:0]         mode_q, mode_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [POS_W-1:0]   line_q, line_d;
  logic [POS_W-1:0]   col_q, col_d;
  logic [POS_W-1:0]   tok_line_q, tok_line_d;
  logic [POS_W-1:0]   tok_col_q, tok_col_d;
  logic [SYM_W-1:0]   held_sym_q, held_sym_d;
  logic               held_valid_q, held_valid_d;
  logic [KIND_W-1:0]  held_kind_q, held_kind_d;
  logic [SLEN_W-1:0]  str_len_q, str_len_d;
  logic [SLEN_W-1:0]  max_len_q;

  res_t               res_c [2];
  logic [1:0]         res_cnt_c;
  logic               do_start;
  logic               do_append;
  logic [SYM_W-1:0]   app_sym;
  logic [KIND_W-1:0]  pair_kind;
  logic [SYM_W-1:0]   b;

  res_t               queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  count_q;
  logic               in_acc, out_acc;

  assign b       = source_byte_i;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  assign cfg_ready_o = 1'b1;
  // Room must remain for the two words the worst input word can produce.
  assign in_stall_o  = count_q > QCNT_W'(QUEUE_DEPTH - 2);

  // Scanner next state and the result words of the current input word.
  always_comb begin
    mode_d       = mode_q;
    depth_d      = depth_q;
    line_d       = line_q;
    col_d        = col_q;
    tok_line_d   = tok_line_q;
    tok_col_d    = tok_col_q;
    held_sym_d   = held_sym_q;
    held_valid_d = held_valid_q;
    held_kind_d  = held_kind_q;
    str_len_d    = str_len_q;
    res_c[0]     = mk_res('0, '0, '0, '0, 1'b0, 1'b0);
    res_c[1]     = mk_res('0, '0, '0, '0, 1'b0, 1'b0);
    res_cnt_c    = 2'd0;
    do_start     = 1'b0;
    do_append    = 1'b0;
    app_sym      = b;
    pair_kind    = KIND_ASSIGN;

    if (end_of_source_i) begin
      // Close whatever is open, then return to the start-of-source state.
      unique case (mode_q) inside
        M_INT, M_IDENT, M_PEND: begin
          res_c[0]  = mk_res(held_kind_q, tok_line_q, tok_col_q, held_sym_q, 1'b1, 1'b1);
          res_c[1]  = mk_res(KIND_EOF, line_q, col_q, '0, 1'b0, 1'b1);
          res_cnt_c = 2'd2;
        end
        M_STRING, M_ESC: begin
          res_c[0]  = mk_res(KIND_ERR_STR, tok_line_q, tok_col_q, '0, 1'b0, 1'b1);
          res_cnt_c = 2'd1;
        end
        M_BLOCK, M_BPAREN, M_BSTAR: begin
          res_c[0]  = mk_res(KIND_ERR_CMT, tok_line_q, tok_col_q, '0, 1'b0, 1'b1);
          res_cnt_c = 2'd1;
        end
        M_ERROR: begin
        end
        default: begin
          res_c[0]  = mk_res(KIND_EOF, line_q, col_q, '0, 1'b0, 1'b1);
          res_cnt_c = 2'd1;
        end
      endcase
      mode_d       = M_IDLE;
      depth_d      = '0;
      line_d       = POS_W'(1);
      col_d        = POS_W'(1);
      tok_line_d   = '0;
      tok_col_d    = '0;
      held_sym_d   = '0;
      held_valid_d = 1'b0;
      held_kind_d  = '0;
      str_len_d    = '0;
    end else begin
      unique case (mode_q) inside
        M_IDLE: begin
          do_start = 1'b1;
        end
        M_INT, M_IDENT: begin
          if ((mode_q == M_INT) ? is_digit(b) : is_word(b)) begin
            // The held symbol is not the last one; send it and hold the new one.
            res_c[0]   = mk_res(held_kind_q, tok_line_q, tok_col_q, held_sym_q, 1'b1, 1'b0);
            res_cnt_c  = 2'd1;
            held_sym_d = b;
          end else begin
            res_c[0]     = mk_res(held_kind_q, tok_line_q, tok_col_q, held_sym_q, 1'b1, 1'b1);
            res_cnt_c    = 2'd1;
            held_valid_d = 1'b0;
            mode_d       = M_IDLE;
            do_start     = 1'b1;
          end
        end
        M_PEND: begin
          if ((held_sym_q == CH_LT) && ((b == CH_MINUS) || (b == CH_EQ))) begin
            pair_kind    = (b == CH_MINUS) ? KIND_ASSIGN : KIND_LE;
            res_c[0]     = mk_res(pair_kind, tok_line_q, tok_col_q, CH_LT, 1'b1, 1'b0);
            res_c[1]     = mk_res(pair_kind, tok_line_q, tok_col_q, b, 1'b1, 1'b1);
            res_cnt_c    = 2'd2;
            held_valid_d = 1'b0;
            mode_d       = M_IDLE;
          end else if ((held_sym_q == CH_MINUS) && (b == CH_MINUS)) begin
            held_valid_d = 1'b0;
            mode_d       = M_LINE;
          end else if ((held_sym_q == CH_LPAREN) && (b == CH_STAR)) begin
            held_valid_d = 1'b0;
            depth_d      = DEPTH_W'(1);
            mode_d       = M_BLOCK;
          end else begin
            res_c[0]     = mk_res(held_kind_q, tok_line_q, tok_col_q, held_sym_q, 1'b1, 1'b1);
            res_cnt_c    = 2'd1;
            held_valid_d = 1'b0;
            mode_d       = M_IDLE;
            do_start     = 1'b1;
          end
        end
        M_LINE: begin
          if (b == CH_LF) begin
            mode_d = M_IDLE;
          end
        end
        M_BLOCK, M_BPAREN, M_BSTAR: begin
          // Nested block comments: track "(*" and "*)" across byte pairs.
          if ((mode_q == M_BPAREN) && (b == CH_STAR)) begin
            if (depth_q < MAX_COMMENT_DEPTH) begin
              depth_d = depth_q + DEPTH_W'(1);
            end
            mode_d = M_BLOCK;
          end else if ((mode_q == M_BSTAR) && (b == CH_RPAREN)) begin
            depth_d = (depth_q != '0) ? depth_q - DEPTH_W'(1) : depth_q;
            mode_d  = (depth_d == '0) ? M_IDLE : M_BLOCK;
          end else if (b == CH_LPAREN) begin
            mode_d = M_BPAREN;
          end else if (b == CH_STAR) begin
            mode_d = M_BSTAR;
          end else begin
            mode_d = M_BLOCK;
          end
        end
        M_STRING: begin
          if (b == CH_QUOTE) begin
            res_c[0]     = mk_res(KIND_STRING, tok_line_q, tok_col_q, held_sym_q,
                                  held_valid_q, 1'b1);
            res_cnt_c    = 2'd1;
            held_valid_d = 1'b0;
            mode_d       = M_IDLE;
          end else if (b == CH_BSLASH) begin
            mode_d = M_ESC;
          end else if (b == CH_LF) begin
            res_c[0]     = mk_res(KIND_ERR_STR, tok_line_q, tok_col_q, '0, 1'b0, 1'b1);
            res_cnt_c    = 2'd1;
            held_valid_d = 1'b0;
            mode_d       = M_ERROR;
          end else begin
            do_append = 1'b1;
          end
        end
        M_ESC: begin
          case (b)
            CH_LB:   app_sym = CH_BS;
            CH_LT_T: app_sym = CH_TAB;
            CH_LN:   app_sym = CH_LF;
            CH_LF_F: app_sym = CH_FF;
            default: app_sym = b;
          endcase
          mode_d    = M_STRING;
          do_append = 1'b1;
        end
        default: begin
          mode_d = M_ERROR;
        end
      endcase

      // Add one symbol to a string: release the pending one, check the limit.
      if (do_append) begin
        if (held_valid_q) begin
          res_c[0]  = mk_res(KIND_STRING, tok_line_q, tok_col_q, held_sym_q, 1'b1, 1'b0);
          res_cnt_c = 2'd1;
        end
        if (str_len_q >= max_len_q) begin
          res_c[res_cnt_c[0]] = mk_res(KIND_ERR_LONG, tok_line_q, tok_col_q, '0, 1'b0, 1'b1);
          res_cnt_c           = res_cnt_c + 2'd1;
          held_valid_d        = 1'b0;
          mode_d              = M_ERROR;
        end else begin
          held_sym_d   = app_sym;
          held_kind_d  = KIND_STRING;
          held_valid_d = 1'b1;
          str_len_d    = str_len_q + SLEN_W'(1);
        end
      end

      // Begin a new token at the current position.
      if (do_start) begin
        tok_line_d   = line_q;
        tok_col_d    = col_q;
        held_valid_d = 1'b0;
        if (is_space(b)) begin
          mode_d = M_IDLE;
        end else if (is_digit(b)) begin
          held_sym_d   = b;
          held_kind_d  = KIND_INT;
          held_valid_d = 1'b1;
          mode_d       = M_INT;
        end else if (b == CH_QUOTE) begin
          held_kind_d = KIND_STRING;
          str_len_d   = '0;
          mode_d      = M_STRING;
        end else if (is_upper(b) || is_lower(b) || (b == CH_UNDER)) begin
          held_sym_d   = b;
          held_kind_d  = is_upper(b) ? KIND_TYPE_ID : KIND_OBJECT_ID;
          held_valid_d = 1'b1;
          mode_d       = M_IDENT;
        end else if ((b == CH_LT) || (b == CH_MINUS) || (b == CH_LPAREN)) begin
          held_sym_d   = b;
          held_kind_d  = op_kind(b);
          held_valid_d = 1'b1;
          mode_d       = M_PEND;
        end else begin
          res_c[res_cnt_c[0]] = mk_res(op_kind(b), line_q, col_q, b, 1'b1, 1'b1);
          res_cnt_c           = res_cnt_c + 2'd1;
          mode_d              = M_IDLE;
        end
      end

      // Saturating line and column counters.
      if (b == CH_LF) begin
        if (line_q != POS_MAX) begin
          line_d = line_q + POS_W'(1);
        end
        col_d = POS_W'(1);
      end else if (col_q != POS_MAX) begin
        col_d = col_q + POS_W'(1);
      end
    end

    // Flag the final word of this input word.
    if (res_cnt_c == 2'd2) begin
      res_c[1].last = 1'b1;
    end else if (res_cnt_c == 2'd1) begin
      res_c[0].last = 1'b1;
    end
  end

  // Scanner state and configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= M_IDLE;
      depth_q      <= '0;
      line_q       <= POS_W'(1);
      col_q        <= POS_W'(1);
      tok_line_q   <= '0;
      tok_col_q    <= '0;
      held_sym_q   <= '0;
      held_valid_q <= 1'b0;
      held_kind_q  <= '0;
      str_len_q    <= '0;
      max_len_q    <= MAX_LEN_RESET;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        max_len_q <= cfg_data_i;
      end
      if (in_acc) begin
        mode_q       <= mode_d;
        depth_q      <= depth_d;
        line_q       <= line_d;
        col_q        <= col_d;
        tok_line_q   <= tok_line_d;
        tok_col_q    <= tok_col_d;
        held_sym_q   <= held_sym_d;
        held_valid_q <= held_valid_d;
        held_kind_q  <= held_kind_d;
        str_len_q    <= str_len_d;
      end
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(res_cnt_c);
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_q + (in_acc ? QCNT_W'(res_cnt_c) : '0) - QCNT_W'(out_acc);
    end
  end

  // Result queue storage: up to two words written per input word.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (res_cnt_c != 2'd0) begin
        queue_q[wr_ptr_q] <= res_c[0];
      end
      if (res_cnt_c == 2'd2) begin
        queue_q[wr_ptr_q + QPTR_W'(1)] <= res_c[1];
      end
    end
  end

  // Head of the queue drives the output word.
  assign out_valid_o    = count_q != '0;
  assign token_kind_o   = queue_q[rd_ptr_q].kind;
  assign start_line_o   = queue_q[rd_ptr_q].line;
  assign start_column_o = queue_q[rd_ptr_q].column;
  assign text_symbol_o  = queue_q[rd_ptr_q].sym;
  assign has_symbol_o   = queue_q[rd_ptr_q].has;
  assign token_end_o    = queue_q[rd_ptr_q].tend;
  assign run_last_o     = queue_q[rd_ptr_q].last;

endmodule

FILE: design/stt_checker.sv
// Port-level checks for source_text_tokenizer, attached by the bind at the end of this file.
// Depends on stt_pkg for widths and token kinds.
module stt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [stt_pkg::KIND_W-1:0] token_kind_o,
  input logic [stt_pkg::POS_W-1:0]  start_line_o,
  input logic [stt_pkg::POS_W-1:0]  start_column_o,
  input logic [stt_pkg::SYM_W-1:0]  text_symbol_o,
  input logic                       has_symbol_o,
  input logic                       token_end_o,
  input logic                       run_last_o
);
  import stt_pkg::*;

  // A stalled output word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(token_kind_o) &&
      $stable(text_symbol_o) && $stable(start_line_o) && $stable(start_column_o) &&
      $stable(has_symbol_o) && $stable(token_end_o) && $stable(run_last_o))
    else $error("stalled output word changed");

  // A word without a symbol always closes its token and carries a zero symbol.
  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_symbol_o |-> token_end_o && (text_symbol_o == '0))
    else $error("symbol-less word not closing its token");

  // End-of-file and error words never carry text.
  a_eof_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((token_kind_o == KIND_EOF) || (token_kind_o == KIND_ERR_STR) ||
      (token_kind_o == KIND_ERR_LONG) || (token_kind_o == KIND_ERR_CMT))
      |-> !has_symbol_o && token_end_o)
    else $error("eof or error word carries text");

  // The first half of a two-character operator is always the less-than sign.
  a_pair_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((token_kind_o == KIND_ASSIGN) || (token_kind_o == KIND_LE)) &&
      !token_end_o |-> (text_symbol_o == CH_LT) && !run_last_o)
    else $error("two-character operator opens with the wrong symbol");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);
